// ===== src/spa_pkg.sv =====
// Package for the sparse polynomial adder: word types, FSM states, defaults.
// No dependencies; imported by every module of the block.
package spa_pkg;

  localparam int unsigned MaxTermsDef = 32;
  localparam int unsigned CoefW       = 32;
  localparam int unsigned ExpnW       = 16;

  typedef struct packed {
    logic                    func;
    logic                    term_present;
    logic signed [CoefW-1:0] term_coef;
    logic signed [ExpnW-1:0] term_expn;
    logic                    end_of_poly;
  } in_word_t;

  typedef struct packed {
    logic signed [CoefW-1:0] out_coef;
    logic signed [ExpnW-1:0] out_expn;
    logic                    out_present;
    logic                    out_last;
    logic                    load_overflow;
  } out_word_t;

  typedef struct packed {
    logic signed [CoefW-1:0] coef;
    logic signed [ExpnW-1:0] expn;
  } term_t;

  localparam logic FuncLoadA = 1'b0;
  localparam logic FuncLoadB = 1'b1;

  typedef enum logic [1:0] {
    StIdle,
    StRead,
    StEval,
    StFlush
  } spa_state_e;

endpackage

// ===== src/sparse_polynomial_add.sv =====
// Sparse polynomial adder: loads A then B, merges on B's end, saturating sums.
// Words are loaded while idle; the merge steps the shared compare/add unit
// (read the two stores, then evaluate) until both stores are used up, then
// flushes the pending term, or an empty word, marked as the last word.
// Results leave through an output register; in_ready_o is low during the merge.
// Reset (asynchronous, active low) clears counts, overflow, FSM and output valid.
module sparse_polynomial_add #(
  parameter int unsigned MaxTerms = spa_pkg::MaxTermsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  spa_pkg::in_word_t in_word_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output spa_pkg::out_word_t out_word_o
);
  import spa_pkg::*;

  localparam int unsigned IdxW = (MaxTerms > 1) ? $clog2(MaxTerms) : 1;
  localparam int unsigned CntW = $clog2(MaxTerms + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MaxTerms);

  spa_state_e state_q, state_d;
  logic [CntW-1:0] a_cnt_q, a_cnt_d, b_cnt_q, b_cnt_d;
  logic [CntW-1:0] i_q, i_d, j_q, j_d;
  logic            ovf_q, ovf_d;
  logic            pend_v_q, pend_v_d;
  term_t           pend_q, pend_d;
  logic            out_valid_q, out_valid_d;
  out_word_t       out_q, out_d;

  logic   accept, we_a, we_b, out_free;
  term_t  wterm, a_rd, b_rd;
  logic   i_ok, j_ok, take_a, take_b, cand_v;
  logic signed [CoefW:0] sum_w;
  logic signed [CoefW-1:0] sum_sat;
  term_t  cand;

  assign accept   = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == StIdle);
  assign out_free = !out_valid_q || out_ready_i;
  assign wterm    = '{coef: in_word_i.term_coef, expn: in_word_i.term_expn};

  assign we_a = accept && in_word_i.term_present && (in_word_i.func == FuncLoadA)
                && (a_cnt_q < CntMax);
  assign we_b = accept && in_word_i.term_present && (in_word_i.func == FuncLoadB)
                && (b_cnt_q < CntMax);

  spa_term_ram #(.Depth(MaxTerms), .IdxW(IdxW)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (a_cnt_q[IdxW-1:0]),
    .wdata_i (wterm),
    .raddr_i (i_q[IdxW-1:0]),
    .rdata_o (a_rd)
  );

  spa_term_ram #(.Depth(MaxTerms), .IdxW(IdxW)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (b_cnt_q[IdxW-1:0]),
    .wdata_i (wterm),
    .raddr_i (j_q[IdxW-1:0]),
    .rdata_o (b_rd)
  );

  // shared compare / saturating add
  always_comb begin
    i_ok   = (i_q < a_cnt_q);
    j_ok   = (j_q < b_cnt_q);
    take_a = !j_ok || (i_ok && (a_rd.expn < b_rd.expn));
    take_b = !take_a && (!i_ok || (a_rd.expn > b_rd.expn));
    sum_w  = {a_rd.coef[CoefW-1], a_rd.coef} + {b_rd.coef[CoefW-1], b_rd.coef};
    if (sum_w[CoefW] != sum_w[CoefW-1]) begin
      sum_sat = sum_w[CoefW] ? {1'b1, {(CoefW-1){1'b0}}} : {1'b0, {(CoefW-1){1'b1}}};
    end else begin
      sum_sat = sum_w[CoefW-1:0];
    end
    if (take_a) begin
      cand = a_rd;
    end else if (take_b) begin
      cand = b_rd;
    end else begin
      cand = '{coef: sum_sat, expn: a_rd.expn};
    end
    cand_v = take_a || take_b || (sum_sat != '0);
  end

  always_comb begin
    state_d     = state_q;
    a_cnt_d     = a_cnt_q;
    b_cnt_d     = b_cnt_q;
    i_d         = i_q;
    j_d         = j_q;
    ovf_d       = ovf_q;
    pend_v_d    = pend_v_q;
    pend_d      = pend_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    case (state_q)
      StIdle: begin
        if (accept) begin
          if (we_a) a_cnt_d = a_cnt_q + 1'b1;
          if (we_b) b_cnt_d = b_cnt_q + 1'b1;
          if (in_word_i.term_present && !we_a && !we_b) ovf_d = 1'b1;
          if ((in_word_i.func == FuncLoadB) && in_word_i.end_of_poly) begin
            i_d      = '0;
            j_d      = '0;
            pend_v_d = 1'b0;
            state_d  = StRead;
          end
        end
      end
      StRead: begin
        state_d = ((i_q < a_cnt_q) || (j_q < b_cnt_q)) ? StEval : StFlush;
      end
      StEval: begin
        if (out_free) begin
          if (!take_b) i_d = i_q + 1'b1;
          if (!take_a) j_d = j_q + 1'b1;
          if (cand_v) begin
            if (pend_v_q) begin
              out_valid_d = 1'b1;
              out_d = '{out_coef: pend_q.coef, out_expn: pend_q.expn, out_present: 1'b1,
                        out_last: 1'b0, load_overflow: ovf_q};
            end
            pend_v_d = 1'b1;
            pend_d   = cand;
          end
          state_d = StRead;
        end
      end
      StFlush: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (pend_v_q) begin
            out_d = '{out_coef: pend_q.coef, out_expn: pend_q.expn, out_present: 1'b1,
                      out_last: 1'b1, load_overflow: ovf_q};
          end else begin
            out_d = '{out_coef: '0, out_expn: '0, out_present: 1'b0,
                      out_last: 1'b1, load_overflow: ovf_q};
          end
          pend_v_d = 1'b0;
          a_cnt_d  = '0;
          b_cnt_d  = '0;
          ovf_d    = 1'b0;
          state_d  = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      a_cnt_q     <= '0;
      b_cnt_q     <= '0;
      i_q         <= '0;
      j_q         <= '0;
      ovf_q       <= 1'b0;
      pend_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      a_cnt_q     <= a_cnt_d;
      b_cnt_q     <= b_cnt_d;
      i_q         <= i_d;
      j_q         <= j_d;
      ovf_q       <= ovf_d;
      pend_v_q    <= pend_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

// ===== src/spa_term_ram.sv =====
// Term store for one polynomial: single write port, one registered read port.
// Depends on spa_pkg for the term type.
module spa_term_ram #(
  parameter int unsigned Depth = 32,
  parameter int unsigned IdxW  = 5
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [IdxW-1:0]      waddr_i,
  input  spa_pkg::term_t       wdata_i,
  input  logic [IdxW-1:0]      raddr_i,
  output spa_pkg::term_t       rdata_o
);
  import spa_pkg::*;

  term_t mem_q [Depth];
  term_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/spa_checker.sv =====
// Port-level checks for sparse_polynomial_add, attached by bind.
// Depends on spa_pkg for the word types.
module spa_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input spa_pkg::in_word_t  in_word_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input spa_pkg::out_word_t out_word_o
);
  import spa_pkg::*;

  // a held result word keeps still
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))
    else $error("output word changed while stalled");

  // empty sum is a single, last, zero word
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.out_present |->
      out_word_o.out_last && (out_word_o.out_coef == '0) && (out_word_o.out_expn == '0))
    else $error("malformed empty result");

  // no loading while a merge is still producing words
  a_busy_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.out_last |-> !in_ready_o)
    else $error("input ready during merge");

  // end of B starts the merge
  a_merge_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_word_i.func == FuncLoadB) && in_word_i.end_of_poly
      |=> !in_ready_o)
    else $error("merge did not start");

endmodule

bind sparse_polynomial_add spa_checker u_spa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_word_i   (in_word_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_word_o  (out_word_o)
);
